// ===== design/u8cpd_pkg.sv =====
// ============================================================================
// u8cpd_pkg
// Shared types and constants for the UTF-8 code point decoder.
// ============================================================================
package u8cpd_pkg;

    localparam int BYTE_W  = 8;
    localparam int CP_W    = 21;
    localparam int PEND_W  = 2;
    localparam int TDATA_W = 24;   // code point padded to whole bytes
    localparam int TUSER_W = 2;    // truncated, terminator

    // One decoded result as it waits in the output stage
    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            truncated;
        logic            terminator;
        logic            last_of_run;
    } u8cpd_result_t;

    // Build a result; a zero code point always terminates the string
    function automatic u8cpd_result_t make_result(input logic [CP_W-1:0] cp,
                                                  input logic            trunc);
        u8cpd_result_t r;
        r.code_point  = cp;
        r.truncated   = trunc;
        r.terminator  = (cp == '0);
        r.last_of_run = 1'b0;
        return r;
    endfunction

endpackage

// ===== design/utf8_codepoint_decoder_top.sv =====
// ============================================================================
// utf8_codepoint_decoder_top
// Lenient UTF-8 decoder: one byte per beat in, zero, one or two code points out.
// ============================================================================
// Latency: the first result of a byte is presented on the cycle after the byte is taken.
// Throughput: one byte per cycle while each byte yields at most one result and
// m_tready stays high; a byte that yields two results holds the input while
// the two-entry output stage drains, as the output port moves one per cycle.
// Reset: asynchronous, active low; clears sequence state and empties output.
// ============================================================================
module utf8_codepoint_decoder_top (
    input  logic                          clk,
    input  logic                          rst_n,
    // input byte stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [u8cpd_pkg::BYTE_W-1:0]  s_tdata,   // [7:0] text_byte
    input  logic                          s_tlast,   // end_of_text
    // decoded code point stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [u8cpd_pkg::TDATA_W-1:0] m_tdata,   // [20:0] code_point, [23:21] zero
    output logic [u8cpd_pkg::TUSER_W-1:0] m_tuser,   // [0] truncated, [1] terminator
    output logic                          m_tlast    // last_of_run
);
    import u8cpd_pkg::*;

    // ------------------------------------------------------------------
    // Sequence state: continuation bytes still expected, code point built
    // so far, and the stopped flag set once a terminator has been seen.
    // ------------------------------------------------------------------
    logic [PEND_W-1:0] pend_reg,    pend_next;
    logic [CP_W-1:0]   partial_reg, partial_next;
    logic              stopped_reg, stopped_next;

    // Output stage: up to two results of one byte, slot0 at the port
    u8cpd_result_t slot0_reg, slot0_next;
    u8cpd_result_t slot1_reg, slot1_next;
    logic [1:0]    cnt_reg,   cnt_next;

    // Results of the byte at the input port
    u8cpd_result_t res0_c, res1_c;
    logic [1:0]    nres_c;

    logic in_beat;
    logic out_beat;

    // Take a byte when the stage is empty or its last entry leaves now
    assign s_tready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_tready);
    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = {{(TDATA_W-CP_W){1'b0}}, slot0_reg.code_point};
    assign m_tuser  = {slot0_reg.terminator, slot0_reg.truncated};
    assign m_tlast  = slot0_reg.last_of_run;

    // ------------------------------------------------------------------
    // Decode one byte against the current state. Three steps in order:
    // continue or cut a pending sequence, handle the byte as a lead, then
    // flush a pending partial on end of text. Each emitted zero stops until end of text.
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [BYTE_W-1:0] b;
        logic              cont;
        logic              take_lead;
        logic [PEND_W-1:0] pc;
        logic [CP_W-1:0]   pv;
        logic              stp;
        logic [1:0]        n;
        logic [CP_W-1:0]   bits;
        u8cpd_result_t     r;

        b         = s_tdata;
        cont      = (b[7:6] == 2'b10);
        take_lead = 1'b1;
        pc        = pend_reg;
        pv        = partial_reg;
        stp       = stopped_reg;
        n         = 2'd0;
        res0_c    = make_result('0, 1'b0);
        res1_c    = make_result('0, 1'b0);
        bits      = '0;
        r         = make_result('0, 1'b0);

        // Step 1: pending sequence
        if (!stp && (pc != '0))
        begin
            if (cont)
            begin
                pc = pc - 1'b1;
                case (pc)
                    2'd0:    bits = {{(CP_W-6){1'b0}}, b[5:0]};
                    2'd1:    bits = {{(CP_W-12){1'b0}}, b[5:0], 6'd0};
                    default: bits = {{(CP_W-18){1'b0}}, b[5:0], 12'd0};
                endcase
                pv = pv | bits;
                if (pc == '0)
                begin
                    r  = make_result(pv, 1'b0);
                    pv = '0;
                    if (r.terminator)
                    begin
                        stp = 1'b1;
                    end
                    res0_c = r;
                    n      = 2'd1;
                end
                take_lead = 1'b0;
            end
            else
            begin
                // cut short: emit what was built, missing bits as zero
                r  = make_result(pv, 1'b1);
                pc = '0;
                pv = '0;
                if (r.terminator)
                begin
                    stp = 1'b1;
                end
                res0_c = r;
                n      = 2'd1;
            end
        end

        // Step 2: lead byte
        if (!stp && take_lead)
        begin
            if (b[7] == 1'b0)
            begin
                r = make_result({{(CP_W-BYTE_W){1'b0}}, b}, 1'b0);
            end
            else if (b[7:5] == 3'b110)
            begin
                pv = {{(CP_W-11){1'b0}}, b[4:0], 6'd0};
                pc = 2'd1;
            end
            else if (b[7:4] == 4'b1110)
            begin
                pv = {{(CP_W-16){1'b0}}, b[3:0], 12'd0};
                pc = 2'd2;
            end
            else if (b[7:3] == 5'b11110)
            begin
                pv = {b[2:0], 18'd0};
                pc = 2'd3;
            end
            else
            begin
                // stray continuation or 11111xxx: terminate
                r = make_result('0, 1'b0);
            end

            if ((b[7] == 1'b0) || (b[7:6] == 2'b10) || (b[7:3] == 5'b11111))
            begin
                if (r.terminator)
                begin
                    stp = 1'b1;
                    pc  = '0;
                    pv  = '0;
                end
                if (n == 2'd0)
                begin
                    res0_c = r;
                end
                else
                begin
                    res1_c = r;
                end
                n = n + 2'd1;
            end
        end

        // Step 3: end of text flushes a partial and returns to reset
        if (s_tlast)
        begin
            if (!stp && (pc != '0))
            begin
                r = make_result(pv, 1'b1);
                if (n == 2'd0)
                begin
                    res0_c = r;
                end
                else
                begin
                    res1_c = r;
                end
                n = n + 2'd1;
            end
            pc  = '0;
            pv  = '0;
            stp = 1'b0;
        end

        // Mark the final result of this byte
        if (n == 2'd1)
        begin
            res0_c.last_of_run = 1'b1;
        end
        else if (n == 2'd2)
        begin
            res1_c.last_of_run = 1'b1;
        end

        nres_c       = n;
        pend_next    = pc;
        partial_next = pv;
        stopped_next = stp;
    end

    // Output stage load and drain
    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        cnt_next   = cnt_reg;
        if (in_beat)
        begin
            slot0_next = res0_c;
            slot1_next = res1_c;
            cnt_next   = nres_c;
        end
        else if (out_beat)
        begin
            slot0_next = slot1_reg;
            cnt_next   = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg    <= '0;
            partial_reg <= '0;
            stopped_reg <= 1'b0;
            cnt_reg     <= 2'd0;
        end
        else
        begin
            if (in_beat)
            begin
                pend_reg    <= pend_next;
                partial_reg <= partial_next;
                stopped_reg <= stopped_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    // Payload of the output stage needs no reset
    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

// ===== verif/u8cpd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8cpd_checker
// Watches both streams of the UTF-8 decoder, predicts the code points that
// each accepted byte yields and compares every result beat in order.
// ----------------------------------------------------------------------------
module u8cpd_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [u8cpd_pkg::BYTE_W-1:0]  s_tdata,   // [7:0] text_byte
    input  logic                          s_tlast,   // end_of_text
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [u8cpd_pkg::TDATA_W-1:0] m_tdata,   // [20:0] code_point, [23:21] zero
    input  logic [u8cpd_pkg::TUSER_W-1:0] m_tuser,   // [0] truncated, [1] terminator
    input  logic                          m_tlast,   // last_of_run
    output int                            error_count,
    output int                            pending_results
);
    import u8cpd_pkg::*;

    localparam logic [1:0] CONT_TAG  = 2'b10;
    localparam logic [2:0] LEAD2_TAG = 3'b110;
    localparam logic [3:0] LEAD3_TAG = 4'b1110;
    localparam logic [4:0] LEAD4_TAG = 5'b11110;

    // Decoder state as the predictor sees it
    logic [PEND_W-1:0] cont_left;
    logic [CP_W-1:0]   cp_so_far;
    logic              halted;

    u8cpd_result_t expected_cps [$];
    u8cpd_result_t byte_results [$];

    assign pending_results = expected_cps.size();

    task automatic add_result(input logic [CP_W-1:0] cp, input logic trunc);
        u8cpd_result_t r;
        r.code_point  = cp;
        r.truncated   = trunc;
        r.terminator  = (cp == '0);
        r.last_of_run = 1'b0;
        byte_results.push_back(r);
        if (cp == '0)
        begin
            halted    = 1'b1;
            cont_left = '0;
            cp_so_far = '0;
        end
    endtask

    task automatic decode_text_byte(input logic [BYTE_W-1:0] b, input logic eot);
        logic as_lead;
        as_lead = 1'b1;
        byte_results.delete();

        if (!halted && cont_left != '0)
        begin
            if (b[7:6] == CONT_TAG)
            begin
                cont_left = cont_left - 1'b1;
                cp_so_far = cp_so_far | (CP_W'(b[5:0]) << (6 * cont_left));
                if (cont_left == '0)
                begin
                    add_result(cp_so_far, 1'b0);
                    cp_so_far = '0;
                end
                as_lead = 1'b0;
            end
            else
            begin
                // sequence cut short: emit what we have, then retry as a lead
                add_result(cp_so_far, 1'b1);
                cont_left = '0;
                cp_so_far = (byte_results[0].code_point == '0) ? '0 : '0;
            end
        end

        if (!halted && as_lead)
        begin
            if (b[7] == 1'b0)
                add_result(CP_W'(b), 1'b0);
            else if (b[7:5] == LEAD2_TAG)
            begin
                cp_so_far = CP_W'(b[4:0]) << 6;
                cont_left = 2'd1;
            end
            else if (b[7:4] == LEAD3_TAG)
            begin
                cp_so_far = CP_W'(b[3:0]) << 12;
                cont_left = 2'd2;
            end
            else if (b[7:3] == LEAD4_TAG)
            begin
                cp_so_far = CP_W'(b[2:0]) << 18;
                cont_left = 2'd3;
            end
            else
                add_result('0, 1'b0);   // stray continuation or 11111xxx lead
        end

        if (eot)
        begin
            // flush a partial code point, then back to the reset state
            if (!halted && cont_left != '0)
                add_result(cp_so_far, 1'b1);
            cont_left = '0;
            cp_so_far = '0;
            halted    = 1'b0;
        end

        if (byte_results.size() != 0)
            byte_results[byte_results.size()-1].last_of_run = 1'b1;
        foreach (byte_results[i])
            expected_cps.push_back(byte_results[i]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        u8cpd_result_t want;
        if (!rst_n)
        begin
            cont_left   = '0;
            cp_so_far   = '0;
            halted      = 1'b0;
            error_count = 0;
            expected_cps.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
                decode_text_byte(s_tdata, s_tlast);

            if (m_tvalid && m_tready)
            begin
                if (expected_cps.size() == 0)
                begin
                    error_count = error_count + 1;
                    $display("%0t: unexpected result beat: cp=%06h trunc=%0b term=%0b last=%0b",
                             $time, m_tdata[CP_W-1:0], m_tuser[0], m_tuser[1], m_tlast);
                end
                else
                begin
                    want = expected_cps.pop_front();
                    if (m_tdata[CP_W-1:0] !== want.code_point
                        || m_tdata[TDATA_W-1:CP_W] !== '0
                        || m_tuser[0] !== want.truncated
                        || m_tuser[1] !== want.terminator
                        || m_tlast !== want.last_of_run)
                    begin
                        error_count = error_count + 1;
                        $display("%0t: mismatch: expected cp=%06h pad=0 trunc=%0b term=%0b last=%0b,",
                                 $time, want.code_point, want.truncated, want.terminator,
                                 want.last_of_run,
                                 " actual cp=%06h pad=%0h trunc=%0b term=%0b last=%0b",
                                 m_tdata[CP_W-1:0], m_tdata[TDATA_W-1:CP_W],
                                 m_tuser[0], m_tuser[1], m_tlast);
                    end
                end
            end
        end
    end

endmodule

// ===== verif/tb_utf8_codepoint_decoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_codepoint_decoder_top
// Drives byte strings into the UTF-8 decoder: a short hand-picked set of
// sequences first, then randomly built strings that are mostly well formed,
// with cut sequences, stray bytes and terminators mixed in. Both streams
// stall in random bursts; the checker beside the block does the comparing.
// ----------------------------------------------------------------------------
module tb_utf8_codepoint_decoder_top;

    import u8cpd_pkg::*;

    localparam int RANDOM_BYTES = 1200;
    localparam int QUIET_FROM   = 1050;     // no stalls on either side after this
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 200000;

    // lead and continuation prefixes for building sequences
    localparam logic [7:0] LEAD2    = 8'hC0;
    localparam logic [7:0] LEAD3    = 8'hE0;
    localparam logic [7:0] LEAD4    = 8'hF0;
    localparam logic [7:0] BAD_LEAD = 8'hF8;
    localparam logic [7:0] CONT     = 8'h80;

    // Hand-picked strings; bit 8 marks the final byte of a string.
    localparam logic [8:0] DIRECTED_TEXT [25] = '{
        // full 1..4 byte sequences, with the largest one-byte value
        9'h07F, 9'h0C2, 9'h0A9, 9'h0E2, 9'h082, 9'h0AC,
        9'h0F0, 9'h09F, 9'h098, 9'h180,
        // largest four-byte value, a cut two-byte sequence, end-of-text flush
        9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0C3, 9'h041, 9'h1E1,
        // stray continuation stops the string, rest dropped
        9'h080, 9'h041, 9'h142,
        // cut sequence that decodes to zero: the cutting byte is dropped
        9'h0C0, 9'h141,
        // 11111xxx lead on its own
        9'h1FF,
        // zero byte terminates
        9'h000, 9'h141
    };

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [BYTE_W-1:0]  s_tdata;    // [7:0] text_byte
    logic               s_tlast;    // end_of_text
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;    // [20:0] code_point, [23:21] zero
    logic [TUSER_W-1:0] m_tuser;    // [0] truncated, [1] terminator
    logic               m_tlast;    // last_of_run

    int          error_count;
    int          pending_results;
    int          bytes_sent;
    int          cycle_count;
    logic        quiet;
    logic [7:0]  text_q [$];

    utf8_codepoint_decoder_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    u8cpd_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .error_count     (error_count),
        .pending_results (pending_results)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Watchdog: end the run if the decoder hangs somewhere
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Present one byte and hold it until the decoder takes the beat.
    // An optional gap goes in front, with tvalid dropped for its length.
    task automatic send_byte(input logic [7:0] b, input logic eot);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eot;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        bytes_sent = bytes_sent + 1;
        if (bytes_sent >= QUIET_FROM)
            quiet = 1'b1;
    endtask

    // Build one string of a few code points and send it, tlast on its last byte.
    // Most code points are well formed; some sequences lose continuation
    // bytes, and stray continuations, bad leads, zeros and noise are mixed in.
    task automatic send_random_text();
        int kind;
        int n_cont;
        int n_keep;
        logic [7:0] lead;
        text_q.delete();
        repeat ($urandom_range(1, 10))
        begin
            kind = $urandom_range(0, 99);
            if (kind < 35)
                text_q.push_back(8'($urandom_range(1, 127)));
            else if (kind < 86)
            begin
                if (kind < 55)
                begin
                    lead   = LEAD2 | 8'($urandom_range(0, 31));
                    n_cont = 1;
                end
                else if (kind < 70)
                begin
                    lead   = LEAD3 | 8'($urandom_range(0, 15));
                    n_cont = 2;
                end
                else
                begin
                    lead   = LEAD4 | 8'($urandom_range(0, 7));
                    n_cont = 3;
                end
                // now and then cut the sequence short
                n_keep = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n_cont - 1) : n_cont;
                text_q.push_back(lead);
                repeat (n_keep)
                    text_q.push_back(CONT | 8'($urandom_range(0, 63)));
            end
            else if (kind < 90)
                text_q.push_back(CONT | 8'($urandom_range(0, 63)));
            else if (kind < 93)
                text_q.push_back(BAD_LEAD | 8'($urandom_range(0, 7)));
            else if (kind < 95)
                text_q.push_back(8'h00);
            else
                text_q.push_back(8'($urandom_range(0, 255)));
        end
        foreach (text_q[i])
            send_byte(text_q[i], i == text_q.size() - 1);
    endtask

    // Receiver: stall in bursts, then accept for a stretch of cycles
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!quiet && $urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clk);
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        quiet      = 1'b0;
        bytes_sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_TEXT[i])
            send_byte(DIRECTED_TEXT[i][7:0], DIRECTED_TEXT[i][8]);

        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES)
            send_random_text();
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        // let the last byte reach the checker, then drain the results
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/u8cpd_pkg.sv
design/utf8_codepoint_decoder_top.sv
verif/u8cpd_checker.sv
verif/tb_utf8_codepoint_decoder_top.sv
